// ===== rtl/core/rcte_pkg.sv =====
package rcte_pkg;

   typedef enum logic [1:0] {
      OP_CLEAR   = 2'd0,
      OP_ADD_REF = 2'd1,
      OP_CONFIG  = 2'd2,
      OP_LOOKUP  = 2'd3
   } rcte_op_type;

   typedef enum logic [2:0] {
      CSR_ADC   = 3'd0,
      CSR_IF0   = 3'd1,
      CSR_IF1   = 3'd2,
      CSR_IF2   = 3'd3,
      CSR_IF3   = 3'd4,
      CSR_CONV0 = 3'd5,
      CSR_CONV1 = 3'd6,
      CSR_CONV2 = 3'd7
   } rcte_csr_idx_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CALC,
      ST_REF_CHECK,
      ST_REF_LOAD,
      ST_REF_DIV,
      ST_REF_FILL,
      ST_LOOK_READ,
      ST_LOOK_SUM
   } rcte_state_type;

   typedef enum logic {
      RD_BIN,
      RD_LAST
   } rcte_rdsel_type;

   typedef struct packed {
      logic [15:0]       adc_offset;
      logic [3:0][15:0]  if_offset;
      logic [2:0][15:0]  conv_offset;
   } rcte_csr_type;

   localparam rcte_csr_type CSR_RESET = '{
      adc_offset:  16'h2600,
      if_offset:   {16'hDD00, 16'hE300, 16'hE800, 16'hEE00},
      conv_offset: {16'hF700, 16'h0000, 16'h0800}
   };

   typedef struct packed {
      logic           capture;
      logic           calc;
      logic           fig_we;
      logic           clr_start;
      logic           clr_step;
      logic           ref_write;
      rcte_rdsel_type rd_sel;
      logic           last_we;
      logic           div_init;
      logic           div_step;
      logic           fill_init;
      logic           fill_step;
      logic           out_load;
   } rcte_cmd_type;

   typedef struct packed {
      rcte_op_type op;
      logic        bin_zero;
      logic        bin_gt_last;
      logic        clr_done;
      logic        div_done;
      logic        fill_done;
      logic        out_free;
   } rcte_sts_type;

   // Division by 10 after rounding: (mhz + 5) >> 1, then times ceil(2^18 / 5).
   localparam logic [16:0] MHZ_ROUND = 17'd5;
   localparam logic [15:0] MHZ_RECIP = 16'd52429;
   localparam int          MHZ_SHIFT = 18;

   // Division by 1e7 after rounding: (hz + 5e6) >> 7, then times ceil(2^42 / 78125).
   localparam logic [32:0] HZ_ROUND  = 33'd5000000;
   localparam logic [25:0] HZ_RECIP  = 26'd56294996;
   localparam int          HZ_SHIFT  = 42;

   localparam int              DIV_STEPS = 16;
   localparam int              DIV_CNT_W = 5;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS);

   localparam logic signed [18:0] SAT_MAX = 19'sd32767;
   localparam logic signed [18:0] SAT_MIN = -19'sd32768;

   function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
      logic signed [15:0] r;
      if (v > SAT_MAX) begin
         r = 16'sh7FFF;
      end else if (v < SAT_MIN) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/rcte_regs.sv =====
module rcte_regs (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [2:0]          csr_index,
   input  logic [15:0]         csr_wdata,
   output rcte_pkg::rcte_csr_type csr
);
   import rcte_pkg::*;

   rcte_csr_type csr_ff, csr_in;

   always_comb begin
      csr_in = csr_ff;
      if (csr_we) begin
         case (rcte_csr_idx_type'(csr_index))
            CSR_ADC:   csr_in.adc_offset     = csr_wdata;
            CSR_IF0:   csr_in.if_offset[0]   = csr_wdata;
            CSR_IF1:   csr_in.if_offset[1]   = csr_wdata;
            CSR_IF2:   csr_in.if_offset[2]   = csr_wdata;
            CSR_IF3:   csr_in.if_offset[3]   = csr_wdata;
            CSR_CONV0: csr_in.conv_offset[0] = csr_wdata;
            CSR_CONV1: csr_in.conv_offset[1] = csr_wdata;
            CSR_CONV2: csr_in.conv_offset[2] = csr_wdata;
            default:   csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= CSR_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign csr = csr_ff;

endmodule

// ===== rtl/core/rcte_ctrl.sv =====
module rcte_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  rcte_pkg::rcte_sts_type sts,
   output rcte_pkg::rcte_cmd_type cmd
);
   import rcte_pkg::*;

   rcte_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.rd_sel = RD_BIN;
      req_ready  = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            case (sts.op)
               OP_CLEAR: begin
                  cmd.clr_start = 1'b1;
                  state_in      = ST_CLEAR;
               end
               OP_ADD_REF: state_in = ST_REF_CHECK;
               OP_CONFIG: begin
                  cmd.fig_we = 1'b1;
                  state_in   = ST_IDLE;
               end
               OP_LOOKUP: state_in = ST_LOOK_READ;
               default:   state_in = ST_IDLE;
            endcase
         end
         ST_REF_CHECK: begin
            // A reference at bin zero is dropped without writing the table or the last reference bin.
            if (sts.bin_zero) begin
               state_in = ST_IDLE;
            end else begin
               cmd.ref_write = 1'b1;
               cmd.rd_sel    = RD_LAST;
               if (sts.bin_gt_last) begin
                  state_in = ST_REF_LOAD;
               end else begin
                  cmd.last_we = 1'b1;
                  state_in    = ST_IDLE;
               end
            end
         end
         ST_REF_LOAD: begin
            cmd.div_init = 1'b1;
            state_in     = ST_REF_DIV;
         end
         ST_REF_DIV: begin
            if (sts.div_done) begin
               cmd.fill_init = 1'b1;
               state_in      = ST_REF_FILL;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_REF_FILL: begin
            if (sts.fill_done) begin
               cmd.last_we = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               cmd.fill_step = 1'b1;
            end
         end
         ST_LOOK_READ: begin
            state_in = ST_LOOK_SUM;
         end
         ST_LOOK_SUM: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== rtl/core/rcte_dp.sv =====
module rcte_dp #(
   parameter int NUM_BINS = 512
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [1:0]             req_op,
   input  logic [15:0]            req_ref_freq_mhz,
   input  logic signed [7:0]      req_ref_level_db,
   input  logic [1:0]             req_if_gain_sel,
   input  logic [1:0]             req_conv_stages,
   input  logic signed [15:0]     req_frontend_gain,
   input  logic [31:0]            req_lookup_freq_hz,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic signed [15:0]     rsp_cal_offset,
   output logic [8:0]             rsp_cal_bin,
   input  rcte_pkg::rcte_csr_type csr,
   input  rcte_pkg::rcte_cmd_type cmd,
   output rcte_pkg::rcte_sts_type sts
);
   import rcte_pkg::*;

   localparam int BIN_W      = $clog2(NUM_BINS);
   localparam int LAST_RESET = (NUM_BINS - 1 < 400) ? NUM_BINS - 1 : 400;
   localparam int EXT_W      = (BIN_W > 9) ? BIN_W : 9;
   localparam logic [BIN_W-1:0] BIN_TOP = BIN_W'(NUM_BINS - 1);

   // Captured transaction.
   rcte_op_type        op_ff;
   logic [15:0]        mhz_ff;
   logic signed [7:0]  level_ff;
   logic [1:0]         gain_ff;
   logic [1:0]         stages_ff;
   logic signed [15:0] fg_ff;
   logic [31:0]        hz_ff;

   logic [BIN_W-1:0]   bin_ff, bin_in;
   logic [BIN_W-1:0]   last_ff, last_in;
   logic signed [15:0] figure_ff, figure_in;
   logic [BIN_W-1:0]   clr_cnt_ff, clr_cnt_in;

   // Interpolation: one division of the level step by the span, then a
   // running quotient and remainder walk across the bins.
   logic signed [15:0]   start_ff, start_in;
   logic [BIN_W-1:0]     span_ff, span_in;
   logic                 neg_ff, neg_in;
   logic [15:0]          dq_ff, dq_in;
   logic [BIN_W-1:0]     rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [BIN_W-1:0]     fill_ff, fill_in;
   logic [BIN_W-1:0]     ra_ff, ra_in;
   logic [15:0]          qa_ff, qa_in;

   logic [15:0]          tbl_mem [NUM_BINS];
   logic [15:0]          rd_data_ff;
   logic [BIN_W-1:0]     rd_addr;
   logic                 tbl_we;
   logic [BIN_W-1:0]     tbl_waddr;
   logic [15:0]          tbl_wdata;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]   offset_ff;
   logic [8:0]           cal_bin_ff;

   // Bin arithmetic.
   logic [16:0]          mhz_round;
   logic [31:0]          mhz_prod;
   logic [13:0]          mhz_quot;
   logic [32:0]          hz_round;
   logic [51:0]          hz_prod;
   logic [9:0]           hz_quot;
   logic [13:0]          quot_sel;

   logic signed [18:0]   fig_sum;
   logic signed [15:0]   ref_value;
   logic signed [16:0]   diff;
   logic [15:0]          mag;
   logic [BIN_W:0]       trial;
   logic                 trial_ge;
   logic [BIN_W:0]       ra_sum;
   logic                 carry;
   logic [15:0]          qa_next;
   logic signed [16:0]   fill_wide;
   logic [EXT_W-1:0]     bin_ext;

   assign ref_value = {level_ff, 8'h00};

   always_comb begin
      mhz_round = 17'(mhz_ff) + MHZ_ROUND;
      mhz_prod  = 32'(mhz_round[16:1]) * 32'(MHZ_RECIP);
      mhz_quot  = 14'(mhz_prod >> MHZ_SHIFT);
      hz_round  = 33'(hz_ff) + HZ_ROUND;
      hz_prod   = 52'(hz_round[32:7]) * 52'(HZ_RECIP);
      hz_quot   = 10'(hz_prod >> HZ_SHIFT);
      quot_sel  = (op_ff == OP_LOOKUP) ? 14'(hz_quot) : mhz_quot;
      if (32'(quot_sel) > 32'(NUM_BINS - 1)) begin
         bin_in = BIN_TOP;
      end else begin
         bin_in = BIN_W'(quot_sel);
      end
   end

   always_comb begin
      fig_sum = 19'($signed(csr.adc_offset)) + 19'($signed(csr.if_offset[gain_ff]))
              - 19'(fg_ff);
      if (stages_ff >= 2'd1) begin
         fig_sum = fig_sum + 19'($signed(csr.conv_offset[0]));
      end
      if (stages_ff >= 2'd2) begin
         fig_sum = fig_sum + 19'($signed(csr.conv_offset[1]));
      end
      if (stages_ff >= 2'd3) begin
         fig_sum = fig_sum + 19'($signed(csr.conv_offset[2]));
      end
   end

   always_comb begin
      diff     = 17'(ref_value) - 17'($signed(rd_data_ff));
      mag      = diff[16] ? 16'(-diff) : 16'(diff);
      trial    = {rem_ff, dq_ff[15]};
      trial_ge = trial >= {1'b0, span_ff};
      ra_sum   = {1'b0, ra_ff} + {1'b0, rem_ff};
      carry    = ra_sum >= {1'b0, span_ff};
      qa_next  = qa_ff + dq_ff + 16'(carry);
      if (neg_ff) begin
         fill_wide = 17'(start_ff) - $signed({1'b0, qa_next});
      end else begin
         fill_wide = 17'(start_ff) + $signed({1'b0, qa_next});
      end
   end

   always_comb begin
      last_in    = last_ff;
      figure_in  = figure_ff;
      clr_cnt_in = clr_cnt_ff;
      start_in   = start_ff;
      span_in    = span_ff;
      neg_in     = neg_ff;
      dq_in      = dq_ff;
      rem_in     = rem_ff;
      div_cnt_in = div_cnt_ff;
      fill_in    = fill_ff;
      ra_in      = ra_ff;
      qa_in      = qa_ff;
      if (cmd.fig_we) begin
         figure_in = sat16(fig_sum);
      end
      if (cmd.clr_start) begin
         clr_cnt_in = '0;
         last_in    = '0;
      end else if (cmd.clr_step) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
      end
      if (cmd.last_we) begin
         last_in = bin_ff;
      end
      if (cmd.div_init) begin
         start_in   = $signed(rd_data_ff);
         span_in    = bin_ff - last_ff;
         neg_in     = diff[16];
         dq_in      = mag;
         rem_in     = '0;
         div_cnt_in = '0;
      end else if (cmd.div_step) begin
         rem_in     = trial_ge ? BIN_W'(trial - {1'b0, span_ff}) : BIN_W'(trial);
         dq_in      = {dq_ff[14:0], trial_ge};
         div_cnt_in = div_cnt_ff + 1'b1;
      end
      if (cmd.fill_init) begin
         fill_in = last_ff + 1'b1;
         ra_in   = '0;
         qa_in   = '0;
      end else if (cmd.fill_step) begin
         fill_in = fill_ff + 1'b1;
         ra_in   = carry ? BIN_W'(ra_sum - {1'b0, span_ff}) : BIN_W'(ra_sum);
         qa_in   = qa_next;
      end
   end

   always_comb begin
      tbl_we    = 1'b0;
      tbl_waddr = clr_cnt_ff;
      tbl_wdata = '0;
      if (cmd.clr_step) begin
         tbl_we = 1'b1;
      end else if (cmd.ref_write) begin
         tbl_we    = 1'b1;
         tbl_waddr = bin_ff;
         tbl_wdata = ref_value;
      end else if (cmd.fill_step) begin
         tbl_we    = 1'b1;
         tbl_waddr = fill_ff;
         tbl_wdata = fill_wide[15:0];
      end
   end

   assign rd_addr = (cmd.rd_sel == RD_LAST) ? last_ff : bin_ff;

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[tbl_waddr] <= tbl_wdata;
      end
      rd_data_ff <= tbl_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= rcte_op_type'(req_op);
         mhz_ff    <= req_ref_freq_mhz;
         level_ff  <= req_ref_level_db;
         gain_ff   <= req_if_gain_sel;
         stages_ff <= req_conv_stages;
         fg_ff     <= req_frontend_gain;
         hz_ff     <= req_lookup_freq_hz;
      end
      if (cmd.calc) begin
         bin_ff <= bin_in;
      end
      start_ff <= start_in;
      span_ff  <= span_in;
      neg_ff   <= neg_in;
      dq_ff    <= dq_in;
      rem_ff   <= rem_in;
      fill_ff  <= fill_in;
      ra_ff    <= ra_in;
      qa_ff    <= qa_in;
      if (cmd.out_load) begin
         offset_ff  <= sat16(19'(figure_ff) + 19'($signed(rd_data_ff)));
         cal_bin_ff <= bin_ext[8:0];
      end
   end

   assign bin_ext = EXT_W'(bin_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff      <= BIN_W'(LAST_RESET);
         figure_ff    <= '0;
         clr_cnt_ff   <= '0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         last_ff      <= last_in;
         figure_ff    <= figure_in;
         clr_cnt_ff   <= clr_cnt_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign sts.op          = op_ff;
   assign sts.bin_zero    = (bin_ff == '0);
   assign sts.bin_gt_last = (bin_ff > last_ff);
   assign sts.clr_done    = (clr_cnt_ff == BIN_TOP);
   assign sts.div_done    = (div_cnt_ff == DIV_LAST);
   assign sts.fill_done   = (fill_ff == bin_ff);
   assign sts.out_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cal_offset = offset_ff;
   assign rsp_cal_bin    = cal_bin_ff;

   a_fill_inside_span: assert property (@(posedge clock) disable iff (reset)
      cmd.fill_step |-> (fill_ff > last_ff) && (fill_ff < bin_ff))
      else $error("interpolation write outside the span between reference bins");

   a_div_rem_below_span: assert property (@(posedge clock) disable iff (reset)
      cmd.fill_init |-> (rem_ff < span_ff) && (span_ff != '0))
      else $error("divider remainder not below the span");

   a_fill_rem_below_span: assert property (@(posedge clock) disable iff (reset)
      cmd.fill_step |-> (ra_ff < span_ff))
      else $error("running remainder escaped its range");

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over one not yet taken");

endmodule

// ===== rtl/core/rf_calibration_table_engine.sv =====
// Receiver power calibration table engine.
// Request channel (req_*): one transaction carries an op and its fields. Op clear
// zeroes the dB correction table, op add-reference writes one bin and fills
// the bins since the previous reference by linear interpolation, op configure
// builds the frequency-independent figure from the csr_* offsets, and op
// lookup returns figure plus the table entry for a frequency in Hz.
// Only a lookup produces a response transaction (rsp_*).
// A lookup raises rsp_valid in the same cycle that req_ready returns, so a new
// request can be taken in that cycle. An add-reference fills the bins since the
// previous reference only when the new bin lies above the last one, by the
// divider (16 steps) and then a walk of one table write per bin. One transaction
// is in work at a time, sequenced by the controller around a table memory with
// one read and one write port.
// After reset the table is swept to zero, one bin per cycle across all NUM_BINS
// bins, before req_ready rises; csr_* writes are taken at any time.
// A stalled response holds in its output register; the next request is still
// taken, and a following lookup waits only at its final stage.
module rf_calibration_table_engine #(
   parameter int NUM_BINS = 512
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_op,
   input  logic [15:0]        req_ref_freq_mhz,
   input  logic signed [7:0]  req_ref_level_db,
   input  logic [1:0]         req_if_gain_sel,
   input  logic [1:0]         req_conv_stages,
   input  logic signed [15:0] req_frontend_gain,
   input  logic [31:0]        req_lookup_freq_hz,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_cal_offset,
   output logic [8:0]         rsp_cal_bin,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata
);
   import rcte_pkg::*;

   rcte_csr_type csr;
   rcte_cmd_type cmd;
   rcte_sts_type sts;

   rcte_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .csr       (csr)
   );

   rcte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rcte_dp #(
      .NUM_BINS (NUM_BINS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_op             (req_op),
      .req_ref_freq_mhz   (req_ref_freq_mhz),
      .req_ref_level_db   (req_ref_level_db),
      .req_if_gain_sel    (req_if_gain_sel),
      .req_conv_stages    (req_conv_stages),
      .req_frontend_gain  (req_frontend_gain),
      .req_lookup_freq_hz (req_lookup_freq_hz),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_cal_offset     (rsp_cal_offset),
      .rsp_cal_bin        (rsp_cal_bin),
      .csr                (csr),
      .cmd                (cmd),
      .sts                (sts)
   );

endmodule

// ===== sim/rcte_cal_checker.sv =====
`timescale 1ns / 1ps
module rcte_cal_checker #(
   parameter int NUM_BINS = 512
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [1:0]         req_op,
   input  logic [15:0]        req_ref_freq_mhz,
   input  logic signed [7:0]  req_ref_level_db,
   input  logic [1:0]         req_if_gain_sel,
   input  logic [1:0]         req_conv_stages,
   input  logic signed [15:0] req_frontend_gain,
   input  logic [31:0]        req_lookup_freq_hz,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [15:0] rsp_cal_offset,
   input  logic [8:0]         rsp_cal_bin,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata,
   output int                 fail_count,
   output int                 pending_count
);
   import rcte_pkg::*;

   typedef struct packed {
      logic signed [15:0] offset;
      logic [8:0]         bin;
   } lookup_result_type;

   lookup_result_type lookup_results_due[$];

   logic signed [15:0] cal_table [NUM_BINS];
   logic signed [15:0] adc_ofs;
   logic signed [15:0] if_ofs [4];
   logic signed [15:0] conv_ofs [3];
   logic signed [15:0] figure;
   int                 last_ref;
   int                 failures = 0;
   int                 outstanding = 0;

   assign fail_count    = failures;
   assign pending_count = outstanding;

   function automatic logic signed [15:0] clip16(input longint v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   // Writes the new reference bin and walks a straight line from the previous one.
   task automatic add_reference(input logic [15:0] mhz, input logic signed [7:0] level);
      int     nb;
      int     lb;
      longint from_val;
      longint to_val;
      longint span;
      nb = (int'(mhz) + 5) / 10;
      if (nb >= NUM_BINS) nb = NUM_BINS - 1;
      if (nb == 0) return;
      lb = last_ref;
      cal_table[nb] = 16'(int'(level) * 256);
      if (lb < nb) begin
         from_val = cal_table[lb];
         to_val   = cal_table[nb];
         span     = nb - lb;
         for (int b = lb; b < nb; b++) begin
            cal_table[b] = clip16(from_val + longint'(b - lb) * (to_val - from_val) / span);
         end
      end
      last_ref = nb;
   endtask

   always @(posedge clock) begin : track
      lookup_result_type want;
      longint            acc;
      longint            hb;
      if (reset) begin
         for (int i = 0; i < NUM_BINS; i++) cal_table[i] = '0;
         last_ref = (NUM_BINS - 1 < 400) ? NUM_BINS - 1 : 400;
         figure   = '0;
         adc_ofs  = CSR_RESET.adc_offset;
         for (int i = 0; i < 4; i++) if_ofs[i] = CSR_RESET.if_offset[i];
         for (int i = 0; i < 3; i++) conv_ofs[i] = CSR_RESET.conv_offset[i];
         lookup_results_due.delete();
      end else begin
         if (csr_we) begin
            case (rcte_csr_idx_type'(csr_index))
               CSR_ADC:   adc_ofs     = csr_wdata;
               CSR_IF0:   if_ofs[0]   = csr_wdata;
               CSR_IF1:   if_ofs[1]   = csr_wdata;
               CSR_IF2:   if_ofs[2]   = csr_wdata;
               CSR_IF3:   if_ofs[3]   = csr_wdata;
               CSR_CONV0: conv_ofs[0] = csr_wdata;
               CSR_CONV1: conv_ofs[1] = csr_wdata;
               CSR_CONV2: conv_ofs[2] = csr_wdata;
               default: ;
            endcase
         end

         if (rsp_valid && rsp_ready) begin
            if (lookup_results_due.size() == 0) begin
               failures++;
               $display("%0t: lookup response with none outstanding, offset %0d bin %0d",
                        $time, rsp_cal_offset, rsp_cal_bin);
            end else begin
               want = lookup_results_due.pop_front();
               if (rsp_cal_offset !== want.offset) begin
                  failures++;
                  $display("%0t: cal_offset mismatch, expected %0d, actual %0d",
                           $time, want.offset, rsp_cal_offset);
               end
               if (rsp_cal_bin !== want.bin) begin
                  failures++;
                  $display("%0t: cal_bin mismatch, expected %0d, actual %0d",
                           $time, want.bin, rsp_cal_bin);
               end
            end
         end

         if (req_valid && req_ready) begin
            case (rcte_op_type'(req_op))
               OP_CLEAR: begin
                  for (int i = 0; i < NUM_BINS; i++) cal_table[i] = '0;
                  last_ref = 0;
               end
               OP_ADD_REF: add_reference(req_ref_freq_mhz, req_ref_level_db);
               OP_CONFIG: begin
                  acc = longint'(adc_ofs) + longint'(if_ofs[req_if_gain_sel])
                        - longint'(req_frontend_gain);
                  for (int k = 0; k < int'(req_conv_stages); k++) acc += conv_ofs[k];
                  figure = clip16(acc);
               end
               default: begin
                  hb = (longint'(req_lookup_freq_hz) + 5000000) / 10000000;
                  if (hb >= NUM_BINS) hb = NUM_BINS - 1;
                  want.offset = clip16(longint'(figure) + longint'(cal_table[hb]));
                  want.bin    = hb[8:0];
                  lookup_results_due.push_back(want);
               end
            endcase
         end
      end
      outstanding = lookup_results_due.size();
   end

endmodule

// ===== sim/rf_calibration_table_engine_tb.sv =====
`timescale 1ns / 1ps
module rf_calibration_table_engine_tb;
   import rcte_pkg::*;

   localparam int TABLE_BINS    = 512;
   localparam int SETTLE_CYCLES = 600;
   localparam int HOLD_CYCLES   = 400;
   localparam int PHASE_ITEMS   = 96;

   typedef enum int {SET_RESET, SET_MAX, SET_MIN, SET_ZERO, SET_RANDOM} offset_set_type;

   logic               clock              = 1'b0;
   logic               reset              = 1'b1;
   logic               req_valid          = 1'b0;
   logic               req_ready;
   logic [1:0]         req_op             = OP_LOOKUP;
   logic [15:0]        req_ref_freq_mhz   = '0;
   logic signed [7:0]  req_ref_level_db   = '0;
   logic [1:0]         req_if_gain_sel    = '0;
   logic [1:0]         req_conv_stages    = '0;
   logic signed [15:0] req_frontend_gain  = '0;
   logic [31:0]        req_lookup_freq_hz = '0;
   logic               rsp_valid;
   logic               rsp_ready          = 1'b0;
   logic signed [15:0] rsp_cal_offset;
   logic [8:0]         rsp_cal_bin;
   logic               csr_we             = 1'b0;
   logic [2:0]         csr_index          = CSR_ADC;
   logic [15:0]        csr_wdata          = '0;

   int fail_count;
   int pending_count;
   int hold_requests = 0;
   int holds_done    = 0;
   int walk_bin      = 400;
   bit sender_idles  = 1'b1;

   always #5 clock = ~clock;

   rf_calibration_table_engine #(.NUM_BINS(TABLE_BINS)) dut (.*);

   rcte_cal_checker #(.NUM_BINS(TABLE_BINS)) cal_checker (.*);

   // Mostly short gaps, now and then a long one.
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 80) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(30, 90);
   endfunction

   task automatic send_request(input rcte_op_type op, input logic [15:0] mhz,
                               input logic [7:0] level, input logic [1:0] gain_sel,
                               input logic [1:0] stages, input logic [15:0] fe_gain,
                               input logic [31:0] hz);
      int gap;
      int nb;
      req_valid          <= 1'b1;
      req_op             <= op;
      req_ref_freq_mhz   <= mhz;
      req_ref_level_db   <= level;
      req_if_gain_sel    <= gain_sel;
      req_conv_stages    <= stages;
      req_frontend_gain  <= fe_gain;
      req_lookup_freq_hz <= hz;
      do @(posedge clock); while (!req_ready);
      nb = (int'(mhz) + 5) / 10;
      if (op == OP_CLEAR) begin
         walk_bin = 0;
      end else if (op == OP_ADD_REF && nb != 0) begin
         walk_bin = (nb < TABLE_BINS) ? nb : TABLE_BINS - 1;
      end
      if (sender_idles) begin
         gap = idle_gap();
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Drains every lookup, then leaves room for a fill or clear still walking the table.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_offsets(input offset_set_type setting);
      logic [15:0] value;
      for (int i = 0; i < 8; i++) begin
         case (setting)
            SET_MAX:    value = 16'h7FFF;
            SET_MIN:    value = 16'h8000;
            SET_ZERO:   value = '0;
            SET_RANDOM: value = $urandom;
            default: begin
               if (i == int'(CSR_ADC)) value = CSR_RESET.adc_offset;
               else if (i < int'(CSR_CONV0)) value = CSR_RESET.if_offset[i - int'(CSR_IF0)];
               else value = CSR_RESET.conv_offset[i - int'(CSR_CONV0)];
            end
         endcase
         csr_we    <= 1'b1;
         csr_index <= rcte_csr_idx_type'(i);
         csr_wdata <= value;
         @(posedge clock);
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly ascending reference walks with lookups in between, plus clears, configures
   // and stray reference points.
   task automatic run_random_phase(input int item_goal);
      int          sent;
      int          pick;
      int          nb;
      int          b;
      logic [15:0] mhz;
      logic [31:0] hz;
      sent = 0;
      while (sent < item_goal) begin
         mhz  = $urandom;
         hz   = $urandom;
         pick = $urandom_range(0, 99);
         if (pick < 5) begin
            send_request(OP_CLEAR, mhz, $urandom, $urandom, $urandom, $urandom, hz);
            sent++;
         end else if (pick < 32) begin
            pick = $urandom_range(0, 9);
            if (pick < 8) begin
               nb = walk_bin + ((pick == 0) ? int'($urandom_range(41, 160))
                                            : int'($urandom_range(1, 40)));
               if (nb >= TABLE_BINS) begin
                  send_request(OP_CLEAR, mhz, $urandom, $urandom, $urandom, $urandom, hz);
                  sent++;
                  nb = $urandom_range(1, 40);
               end
               mhz = 16'(nb * 10 - 5 + int'($urandom_range(0, 9)));
            end else if (pick == 8) begin
               mhz = $urandom_range(0, 14);
            end
            // A reference point that lands in bin zero is dropped by the block.
            if ((int'(mhz) + 5) / 10 != 0) sent++;
            send_request(OP_ADD_REF, mhz, $urandom, $urandom, $urandom, $urandom, hz);
         end else if (pick < 44) begin
            send_request(OP_CONFIG, mhz, $urandom, $urandom, $urandom, $urandom, hz);
            sent++;
         end else begin
            pick = $urandom_range(0, 3);
            if (pick == 0) begin
               b  = $urandom_range(1, 428);
               hz = 32'(longint'(b) * 10000000 - 5000000 - longint'($urandom_range(0, 1)));
            end else if (pick == 1) begin
               b = walk_bin - int'($urandom_range(0, 30));
               if (b < 0) b = 0;
               if (b > 428) b = $urandom_range(0, 428);
               hz = 32'(longint'(b) * 10000000 + longint'($urandom_range(0, 9999999)));
            end
            send_request(OP_LOOKUP, mhz, $urandom, $urandom, $urandom, $urandom, hz);
            sent++;
         end
      end
   endtask

   initial begin : response_drain
      int gap;
      @(posedge clock);
      forever begin
         if (holds_done < hold_requests) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_done++;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 9) == 0) repeat (200) @(posedge clock);
            else repeat ($urandom_range(1, 24)) @(posedge clock);
            gap = idle_gap();
            if (gap > 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   end

   initial begin : watchdog
      #20_000_000;
      $display("rf_calibration_table_engine_tb: errors");
      $finish;
   end

   initial begin : stimulus
      offset_set_type plan [6];
      plan = '{SET_MAX, SET_MIN, SET_RANDOM, SET_ZERO, SET_RANDOM, SET_RESET};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed pass on the reset offsets. The last reference bin starts at 400.
      send_request(OP_LOOKUP, $urandom, $urandom, $urandom, $urandom, $urandom, 32'd0);
      send_request(OP_ADD_REF, 16'd100, 8'sd5, $urandom, $urandom, $urandom, $urandom);
      send_request(OP_ADD_REF, 16'd204, -8'sd7, $urandom, $urandom, $urandom, $urandom);
      send_request(OP_ADD_REF, 16'd4, 8'sd100, $urandom, $urandom, $urandom, $urandom);
      send_request(OP_ADD_REF, 16'd0, 8'sd100, $urandom, $urandom, $urandom, $urandom);
      send_request(OP_LOOKUP, $urandom, $urandom, $urandom, $urandom, $urandom, 32'd150000000);
      send_request(OP_ADD_REF, 16'hFFFF, 8'h80, $urandom, $urandom, $urandom, $urandom);
      send_request(OP_LOOKUP, $urandom, $urandom, $urandom, $urandom, $urandom, 32'hFFFFFFFF);
      send_request(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      send_request(OP_LOOKUP, $urandom, $urandom, $urandom, $urandom, $urandom, 32'd204000000);
      send_request(OP_ADD_REF, 16'd5, 8'sd127, $urandom, $urandom, $urandom, $urandom);
      send_request(OP_ADD_REF, 16'd3000, 8'sd127, $urandom, $urandom, $urandom, $urandom);
      send_request(OP_ADD_REF, 16'd3500, 8'h80, $urandom, $urandom, $urandom, $urandom);
      send_request(OP_CONFIG, $urandom, $urandom, 2'd3, 2'd3, 16'h8000, $urandom);
      send_request(OP_LOOKUP, $urandom, $urandom, $urandom, $urandom, $urandom, 32'd2995000000);
      send_request(OP_LOOKUP, $urandom, $urandom, $urandom, $urandom, $urandom, 32'd2994999999);
      send_request(OP_CONFIG, $urandom, $urandom, 2'd1, 2'd1, 16'h7FFF, $urandom);
      send_request(OP_LOOKUP, $urandom, $urandom, $urandom, $urandom, $urandom, 32'd3500000000);
      send_request(OP_CONFIG, $urandom, $urandom, 2'd2, 2'd2, 16'h0000, $urandom);
      send_request(OP_LOOKUP, $urandom, $urandom, $urandom, $urandom, $urandom, 32'd3300000000);
      send_request(OP_CONFIG, $urandom, $urandom, 2'd0, 2'd0, 16'hFFFF, $urandom);
      send_request(OP_LOOKUP, $urandom, $urandom, $urandom, $urandom, $urandom, 32'd5000000);
      send_request(OP_LOOKUP, $urandom, $urandom, $urandom, $urandom, $urandom, 32'd4999999);

      for (int p = 0; p < 6; p++) begin
         settle();
         load_offsets(plan[p]);
         // In the second phase the response side holds off while requests keep coming.
         sender_idles = (p != 1);
         if (p == 1) hold_requests++;
         run_random_phase(PHASE_ITEMS);
      end
      settle();

      if (fail_count == 0) begin
         $display("rf_calibration_table_engine_tb: clean");
      end else begin
         $display("rf_calibration_table_engine_tb: errors");
      end
      $finish;
   end

endmodule
